FILE: hdl/gmp_pkg.sv
package gmp_pkg;

  localparam int unsigned MaxColsDef = 256;
  localparam int unsigned MaxRowsDef = 1024;

  localparam int unsigned CountW   = 12;
  localparam int unsigned ValueW   = 24;
  localparam int unsigned NumRowsW = 11;
  localparam int unsigned NumColsW = 9;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumRows = 2'd0,
    CfgNumCols = 2'd1
  } cfg_idx_e;

  // position of a cell inside the matrix
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_row;
    logic last_col;
  } cell_pos_t;

endpackage

FILE: hdl/gmp_ram.sv
module gmp_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gmp_index.sv
module gmp_index #(
  parameter int unsigned MAX_ROWS = gmp_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gmp_pkg::MaxColsDef,
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gmp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gmp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           step_i,
  output logic [ColW-1:0]                col_o,
  output gmp_pkg::cell_pos_t             pos_o
);
  import gmp_pkg::*;

  localparam int unsigned RCmpW = (NumRowsW > RowW + 1) ? NumRowsW : RowW + 1;
  localparam int unsigned CCmpW = (NumColsW > ColW + 1) ? NumColsW : ColW + 1;

  logic [NumRowsW-1:0] num_rows_q;
  logic [NumColsW-1:0] num_cols_q;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;

  logic [RCmpW-1:0] rows_eff, row_next;
  logic [CCmpW-1:0] cols_eff, col_next;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NumRowsW'(1);
      num_cols_q <= NumColsW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgNumRows: num_rows_q <= cfg_data_i[NumRowsW-1:0];
        CfgNumCols: num_cols_q <= cfg_data_i[NumColsW-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize clamps to the maximum
  always_comb begin
    if (num_rows_q == '0) begin
      rows_eff = RCmpW'(1);
    end else if (RCmpW'(num_rows_q) > RCmpW'(MAX_ROWS)) begin
      rows_eff = RCmpW'(MAX_ROWS);
    end else begin
      rows_eff = RCmpW'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      cols_eff = CCmpW'(1);
    end else if (CCmpW'(num_cols_q) > CCmpW'(MAX_COLS)) begin
      cols_eff = CCmpW'(MAX_COLS);
    end else begin
      cols_eff = CCmpW'(num_cols_q);
    end
  end

  always_comb begin
    row_next        = RCmpW'(row_q) + RCmpW'(1);
    col_next        = CCmpW'(col_q) + CCmpW'(1);
    pos_o.first_row = (row_q == '0);
    pos_o.first_col = (col_q == '0);
    pos_o.last_row  = (row_next >= rows_eff);
    pos_o.last_col  = (col_next >= cols_eff);
    row_d = row_q;
    col_d = col_q;
    if (pos_o.last_col) begin
      col_d = '0;
      row_d = pos_o.last_row ? '0 : row_next[RowW-1:0];
    end else begin
      col_d = col_next[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (step_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

FILE: hdl/gmp_cell.sv
module gmp_cell (
  input  logic [gmp_pkg::CountW-1:0] count_i,
  input  logic [gmp_pkg::ValueW-1:0] up_i,
  input  logic [gmp_pkg::ValueW-1:0] left_i,
  input  gmp_pkg::cell_pos_t         pos_i,
  output logic [gmp_pkg::ValueW-1:0] value_o
);
  import gmp_pkg::*;

  logic [ValueW:0]   sum;
  logic [ValueW-1:0] sat;
  logic [ValueW-1:0] count_ext;
  logic [ValueW-1:0] cand;

  always_comb begin
    count_ext = ValueW'(count_i);
    sum       = {1'b0, up_i} + (ValueW + 1)'(count_i);
    sat       = sum[ValueW] ? ValueMax : sum[ValueW-1:0];
    // first row runs a minimum over counts, later rows add the upper value
    cand      = pos_i.first_row ? count_ext : sat;
    if (pos_i.first_col) begin
      value_o = cand;
    end else begin
      value_o = (left_i < cand) ? left_i : cand;
    end
  end

endmodule

FILE: hdl/grid_min_path_resilience_dp.sv
// a cell passes the compute register, then the result register; throughput: one cell
// per cycle unless stalled, bound by the single row buffer read and write port
// a result held by stall keeps one further cell in the compute register
// reset (asynchronous, active low) clears counters, left value and valid flags
// and sets both size registers to one; the row buffer is not cleared
module grid_min_path_resilience_dp #(
  parameter int unsigned MAX_ROWS = gmp_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gmp_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gmp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gmp_pkg::CfgDataW-1:0] cfg_data_i,
  // cell input channel
  input  logic                         cell_valid_i,
  output logic                         cell_stall_o,
  input  logic [gmp_pkg::CountW-1:0]   cell_count_i,
  // result channel
  output logic                         res_valid_o,
  input  logic                         res_stall_i,
  output logic [gmp_pkg::ValueW-1:0]   dp_value_o,
  output logic                         in_last_row_o,
  output logic                         last_cell_o
);
  import gmp_pkg::*;

  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic            in_accept;
  logic            adv;
  logic [ColW-1:0] rd_col;
  cell_pos_t       rd_pos;

  // compute stage: input register plus registered row buffer read
  logic              s1_valid_q;
  logic [CountW-1:0] s1_count_q;
  logic [ColW-1:0]   s1_col_q;
  cell_pos_t         s1_pos_q;

  // forwarding of a row buffer write that collides with the read
  logic              byp_q;
  logic [ValueW-1:0] byp_data_q;

  logic [ValueW-1:0] left_q;
  logic [ValueW-1:0] ram_rdata;
  logic [ValueW-1:0] up_value;
  logic [ValueW-1:0] cell_value;

  // result register
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_last_row_q;
  logic              out_last_cell_q;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // compute stage moves on when the result register is free or being emptied
  assign adv          = s1_valid_q && (!out_valid_q || !res_stall_i);
  assign cell_stall_o = s1_valid_q && !adv;
  assign in_accept    = cell_valid_i && !cell_stall_o;

  // row and column counters with the size registers
  gmp_index #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_accept),
    .col_o       (rd_col),
    .pos_o       (rd_pos)
  );

  // previous row values, read when a cell is accepted, written when it completes
  gmp_ram #(
    .Width (ValueW),
    .Depth (MAX_COLS)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (s1_col_q),
    .wdata_i (cell_value),
    .re_i    (in_accept),
    .raddr_i (rd_col),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      // same column written in this cycle: ram returns the old entry
      byp_q      <= adv && (s1_col_q == rd_col);
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_count_q <= cell_count_i;
      s1_col_q   <= rd_col;
      s1_pos_q   <= rd_pos;
      byp_data_q <= cell_value;
    end
  end

  assign up_value = byp_q ? byp_data_q : ram_rdata;

  // recurrence for one cell
  gmp_cell u_cell (
    .count_i (s1_count_q),
    .up_i    (up_value),
    .left_i  (left_q),
    .pos_i   (s1_pos_q),
    .value_o (cell_value)
  );

  // left neighbour for the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (adv) begin
      left_q <= cell_value;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_value_q     <= cell_value;
      out_last_row_q  <= s1_pos_q.last_row;
      out_last_cell_q <= s1_pos_q.last_row && s1_pos_q.last_col;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign dp_value_o    = out_value_q;
  assign in_last_row_o = out_last_row_q;
  assign last_cell_o   = out_last_cell_q;

endmodule

FILE: tb/sv/grid_min_path_resilience_dp_checker.sv
module grid_min_path_resilience_dp_checker #(
  parameter int unsigned MAX_ROWS = gmp_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gmp_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [gmp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gmp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         cell_valid_i,
  input  logic                         cell_stall_i,
  input  logic [gmp_pkg::CountW-1:0]   cell_count_i,
  input  logic                         res_valid_i,
  input  logic                         res_stall_i,
  input  logic [gmp_pkg::ValueW-1:0]   dp_value_i,
  input  logic                         in_last_row_i,
  input  logic                         last_cell_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import gmp_pkg::*;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last_row;
    logic              last_cell;
  } dp_result_t;

  logic [ValueW-1:0]   upper_row_q [MAX_COLS];
  logic [ValueW-1:0]   left_q;
  int unsigned         col_q;
  int unsigned         row_q;
  logic [NumRowsW-1:0] rows_cfg_q;
  logic [NumColsW-1:0] cols_cfg_q;
  dp_result_t          dp_results_due[$];
  dp_result_t          oldest_due;
  dp_result_t          newest_due;
  int                  mismatches = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // table value of the next cell, advancing the row buffer and the counters
  function automatic dp_result_t next_dp_cell(logic [CountW-1:0] count);
    int unsigned       rows;
    int unsigned       cols;
    int unsigned       col;
    int unsigned       row;
    logic [ValueW:0]   sum;
    logic [ValueW-1:0] up;
    logic [ValueW-1:0] val;
    dp_result_t        r;
    rows = clamp_size(rows_cfg_q, MAX_ROWS);
    cols = clamp_size(cols_cfg_q, MAX_COLS);
    col  = (col_q >= MAX_COLS) ? MAX_COLS - 1 : col_q;
    row  = (row_q >= MAX_ROWS) ? MAX_ROWS - 1 : row_q;
    up   = upper_row_q[col];
    sum  = {1'b0, up} + (ValueW + 1)'(count);
    if (sum > {1'b0, ValueMax}) sum = {1'b0, ValueMax};
    if (row == 0) begin
      if (col == 0) val = ValueW'(count);
      else val = (left_q < ValueW'(count)) ? left_q : ValueW'(count);
    end else if (col == 0) begin
      val = sum[ValueW-1:0];
    end else begin
      val = (left_q < sum[ValueW-1:0]) ? left_q : sum[ValueW-1:0];
    end
    upper_row_q[col] = val;
    left_q           = val;
    r.value     = val;
    r.last_row  = (row + 1 >= rows);
    r.last_cell = r.last_row && (col + 1 >= cols);
    if (col + 1 >= cols) begin
      col_q = 0;
      row_q = r.last_row ? 0 : row + 1;
    end else begin
      col_q = col + 1;
      row_q = row;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     = '0;
      col_q      = 0;
      row_q      = 0;
      rows_cfg_q = NumRowsW'(1);
      cols_cfg_q = NumColsW'(1);
      dp_results_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // result side first: same-edge cell is always younger
      if (res_valid_i && !res_stall_i) begin
        if (dp_results_due.size() == 0) begin
          $error("result with no cell outstanding: dp_value %0d", dp_value_i);
          mismatches++;
        end else begin
          oldest_due = dp_results_due.pop_front();
          if (dp_value_i !== oldest_due.value) begin
            $error("dp_value: expected %0d, actual %0d", oldest_due.value, dp_value_i);
            mismatches++;
          end
          if (in_last_row_i !== oldest_due.last_row) begin
            $error("in_last_row: expected %0b, actual %0b", oldest_due.last_row,
                   in_last_row_i);
            mismatches++;
          end
          if (last_cell_i !== oldest_due.last_cell) begin
            $error("last_cell: expected %0b, actual %0b", oldest_due.last_cell, last_cell_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgNumRows: rows_cfg_q = cfg_data_i[NumRowsW-1:0];
          CfgNumCols: cols_cfg_q = cfg_data_i[NumColsW-1:0];
          default: ;
        endcase
      end
      if (cell_valid_i && !cell_stall_i) begin
        newest_due = next_dp_cell(cell_count_i);
        dp_results_due.insert(dp_results_due.size(), newest_due);
      end
      pending_o    <= dp_results_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/sv/grid_min_path_resilience_dp_tb.sv
module grid_min_path_resilience_dp_tb;
  import gmp_pkg::*;

  // generous bound on the whole run, far above the slowest legal run
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned ItemsPerPhase = 320;
  // indexes with no register behind them, written to check they are ignored
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                cell_valid_i  = 1'b0;
  logic                cell_stall_o;
  logic [CountW-1:0]   cell_count_i  = '0;
  logic                res_valid_o;
  logic                res_stall_i   = 1'b0;
  logic [ValueW-1:0]   dp_value_o;
  logic                in_last_row_o;
  logic                last_cell_o;

  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  logic                hold_go       = 1'b0;
  logic                hold_off      = 1'b0;
  int unsigned         cycle_cnt     = 0;
  int                  fail_count;
  int                  pending_cnt;

  grid_min_path_resilience_dp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cell_valid_i  (cell_valid_i),
    .cell_stall_o  (cell_stall_o),
    .cell_count_i  (cell_count_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .dp_value_o    (dp_value_o),
    .in_last_row_o (in_last_row_o),
    .last_cell_o   (last_cell_o)
  );

  // watches all three channels, predicts every result and compares
  grid_min_path_resilience_dp_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cell_valid_i  (cell_valid_i),
    .cell_stall_i  (cell_stall_o),
    .cell_count_i  (cell_count_i),
    .res_valid_i   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .dp_value_i    (dp_value_o),
    .in_last_row_i (in_last_row_o),
    .last_cell_i   (last_cell_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stall plus the long hold-off when it is running
  always @(posedge clk_i) begin
    res_stall_i <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  // long hold-off, counted here so the sender keeps offering meanwhile
  initial begin
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("grid_min_path_resilience_dp test failed");
      $finish;
    end
  end

  // one cell transaction, entered and left in the time step of a rising edge;
  // valid stays high on exit so back-to-back cells need no extra assignment
  task automatic send_cell(input logic [CountW-1:0] count);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cell_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cell_valid_i <= 1'b1;
    cell_count_i <= count;
    do @(posedge clk_i); while (cell_stall_o);
  endtask

  // valid drops for one cycle after each write, so writes in a row never
  // assign it twice in one time step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering cells and wait until every result has come back; the
  // first edge lets the pending count take in the last accepted cell
  task automatic drain();
    cell_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // mix of extremes, small values and full-range counts so both min paths win
  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CountW'($urandom_range(0, 15));
      4:       return CountW'($urandom_range(3900, 4095));
      default: return CountW'($urandom);
    endcase
  endfunction

  // mostly short matrices so last row and last cell come round often
  function automatic logic [CfgDataW-1:0] pick_rows_data();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return CfgDataW'(MaxRowsDef);
      3:       return CfgDataW'(MaxRowsDef + 1);
      4:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(1, 6));
    endcase
  endfunction

  // data above the field width is masked, over-range values are clamped
  function automatic logic [CfgDataW-1:0] pick_cols_data();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CfgDataW'(MaxColsDef);
      2:       return CfgDataW'(MaxColsDef + 1);
      3:       return CfgDataW'(511);
      4:       return CfgDataW'($urandom);
      5:       return CfgDataW'($urandom_range(200, 255));
      default: return CfgDataW'($urandom_range(1, 12));
    endcase
  endfunction

  // new sizes with the block idle; counters may sit mid-matrix, which is
  // safe once every row buffer entry has been written
  task automatic reconfigure();
    drain();
    case ($urandom_range(0, 5))
      0: write_reg(CfgNumRows, pick_rows_data());
      1: write_reg(CfgNumCols, pick_cols_data());
      2: write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, CfgDataW'($urandom));
      default: begin
        write_reg(CfgNumRows, pick_rows_data());
        write_reg(CfgNumCols, pick_cols_data());
      end
    endcase
  endtask

  initial begin
    logic [CountW-1:0] corner_counts [12];
    int unsigned       ph;
    int unsigned       n;
    int unsigned       next_cfg;
    corner_counts = '{12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'h001, 12'hFFF,
                      12'h000, 12'hFFE, 12'h555, 12'hAAA, 12'hFFF, 12'h000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3 x 4 matrix: first row minimum, first column sum, inner recurrence
    write_reg(CfgNumRows, CfgDataW'(3));
    write_reg(CfgNumCols, CfgDataW'(4));
    foreach (corner_counts[i]) send_cell(corner_counts[i]);
    drain();

    // zero sizes act as one: every cell is a whole matrix
    write_reg(CfgNumRows, '0);
    write_reg(CfgNumCols, '0);
    send_cell('1);
    send_cell('0);
    drain();

    // single column of maximum counts: running sum down the column
    write_reg(CfgNumRows, CfgDataW'(4));
    write_reg(CfgNumCols, CfgDataW'(1));
    repeat (4) send_cell('1);
    drain();

    // one full-width row (over-range column count clamps) fills the whole
    // row buffer before any size change can land mid-matrix
    write_reg(CfgNumRows, CfgDataW'(1));
    write_reg(CfgNumCols, CfgDataW'(511));
    repeat (MaxColsDef) send_cell(pick_count());
    drain();

    // random phases: no idling, sender idle, receiver stalling, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 64;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct    <= 25;
        end
      endcase
      next_cfg = 0;
      for (n = 0; n < ItemsPerPhase; n++) begin
        if (n == next_cfg) begin
          reconfigure();
          next_cfg = n + $urandom_range(15, 60);
        end
        // back-pressure burst while cells keep coming at full rate
        if (ph == 0 && n == 70) hold_go <= 1'b1;
        send_cell(pick_count());
      end
    end

    cell_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("grid_min_path_resilience_dp test passed");
    end else begin
      $display("grid_min_path_resilience_dp test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gmp_pkg.sv
hdl/gmp_ram.sv
hdl/gmp_index.sv
hdl/gmp_cell.sv
hdl/grid_min_path_resilience_dp.sv
tb/sv/grid_min_path_resilience_dp_checker.sv
tb/sv/grid_min_path_resilience_dp_tb.sv
